// File: src/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, constants and saturation helpers for the escape-time evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int WORD_BITS    = 36;
    localparam int FRAC_BITS    = 28;
    localparam int ITER_BITS    = 16;
    localparam int PIX_BITS     = 10;
    localparam int STEP_BITS    = 32;
    localparam int OFF_BITS     = PIX_BITS + STEP_BITS;
    localparam int MAP_BITS     = OFF_BITS + 2;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int Q_BITS       = PROD_BITS - FRAC_BITS;
    localparam int HALF_BITS    = WORD_BITS / 2;
    localparam int COLOUR_BITS  = 24;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_SET_WHITE = 3'd4;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [WORD_BITS:0] FOUR = (WORD_BITS+1)'(4) << FRAC_BITS;

    localparam logic [COLOUR_BITS-1:0] WHITE = 24'hFFFFFF;
    localparam logic [COLOUR_BITS-1:0] BLACK = 24'h000000;

    localparam logic [STEP_BITS-1:0] STEP_RESET   = 32'd1048576;
    localparam word_t                ORIGIN_RESET = -36'sd536870912;
    localparam logic [ITER_BITS-1:0] ITER_RESET   = 16'd50;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_x;
        logic [PIX_BITS-1:0] pixel_y;
    } in_word_t;

    typedef struct packed {
        logic [PIX_BITS-1:0]    out_x;
        logic [PIX_BITS-1:0]    out_y;
        logic [ITER_BITS-1:0]   iterations;
        logic                   in_set;
        logic [COLOUR_BITS-1:0] fill_colour;
    } out_word_t;

    function automatic word_t sat_word(input logic [WORD_BITS:0] s);
        word_t r;
        if (s[WORD_BITS] != s[WORD_BITS-1])
            r = s[WORD_BITS] ? WMIN : WMAX;
        else
            r = word_t'(s[WORD_BITS-1:0]);
        return r;
    endfunction

    function automatic word_t sat_map(input logic [MAP_BITS-1:0] s);
        word_t r;
        if ((&s[MAP_BITS-1:WORD_BITS-1]) || !(|s[MAP_BITS-1:WORD_BITS-1]))
            r = word_t'(s[WORD_BITS-1:0]);
        else
            r = s[MAP_BITS-1] ? WMIN : WMAX;
        return r;
    endfunction

endpackage

// File: src/mandelbrot_escape_time.sv
// Evaluates one pixel per input word: the pixel maps to c = origin + pixel *
// step_size, then z = z*z + c runs from zero until |z|^2 reaches 4.0 or the
// iteration limit is hit. One pixel is in flight at a time; in_ready is high
// only while no pixel is being worked on, though a finished result may still
// wait in the output register. The states S_MAP_RE, S_MAP_IM and S_MAP_END
// map the coordinate. Each iteration forms zr*zr and then zi*zi on the
// shared multiplier (mbe_fxmul), runs the escape test while it starts zi*zr,
// and then the update. The final round forms the two squares and runs the
// escape test. S_DONE then loads the output register, and it waits while an
// unread result still holds the register. A new pixel is taken only once
// the result is loaded and the sequencer is back in S_IDLE.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration for one pixel in signed Q8.28 fixed point with
// saturation, a sequencer around a shared multiplier.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mbe_pkg::WORD_BITS-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mbe_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mbe_pkg::out_word_t                  out_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MAP_RE  = 4'd1;
    localparam logic [3:0] S_MAP_IM  = 4'd2;
    localparam logic [3:0] S_MAP_END = 4'd3;
    localparam logic [3:0] S_SQ_R    = 4'd4;
    localparam logic [3:0] S_WAIT_R  = 4'd5;
    localparam logic [3:0] S_WAIT_I  = 4'd6;
    localparam logic [3:0] S_TEST    = 4'd7;
    localparam logic [3:0] S_WAIT_X  = 4'd8;
    localparam logic [3:0] S_UPDATE  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    localparam int WB = mbe_pkg::WORD_BITS;
    localparam int PB = mbe_pkg::PIX_BITS;
    localparam int IB = mbe_pkg::ITER_BITS;
    localparam int OB = mbe_pkg::OFF_BITS;
    localparam int MB = mbe_pkg::MAP_BITS;

    logic [mbe_pkg::STEP_BITS-1:0] step_reg;
    mbe_pkg::word_t                origin_re_reg;
    mbe_pkg::word_t                origin_im_reg;
    logic [IB-1:0]                 max_iter_reg;
    logic                          white_reg;

    logic [3:0]         state_reg,     state_next;
    logic               out_valid_reg, out_valid_next;
    logic [IB-1:0]      iter_reg,      iter_next;
    logic [PB-1:0]      px_reg,        px_next;
    logic [PB-1:0]      py_reg,        py_next;
    logic [OB-1:0]      off_reg,       off_next;
    mbe_pkg::word_t     cr_reg,        cr_next;
    mbe_pkg::word_t     ci_reg,        ci_next;
    mbe_pkg::word_t     zr_reg,        zr_next;
    mbe_pkg::word_t     zi_reg,        zi_next;
    mbe_pkg::word_t     sr_reg,        sr_next;
    mbe_pkg::word_t     si_reg,        si_next;
    mbe_pkg::word_t     diff_reg,      diff_next;
    mbe_pkg::word_t     cross_reg,     cross_next;
    mbe_pkg::out_word_t out_reg,       out_next;

    logic               mul_start;
    mbe_pkg::word_t     mul_a;
    mbe_pkg::word_t     mul_b;
    logic               mul_done;
    mbe_pkg::word_t     mul_p;

    logic               escape_c;
    logic               inside_c;
    logic [MB-1:0]      map_sum_c;
    logic [MB-1:0]      off_ext_c;

    mbe_fxmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        iter_next      = iter_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        off_next       = off_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        sr_next        = sr_reg;
        si_next        = si_reg;
        diff_next      = diff_reg;
        cross_next     = cross_reg;
        out_next       = out_reg;
        mul_start      = 1'b0;
        mul_a          = zr_reg;
        mul_b          = zr_reg;

        escape_c  = ({1'b0, sr_reg} + {1'b0, si_reg}) >= mbe_pkg::FOUR;
        inside_c  = (iter_reg == max_iter_reg);
        off_ext_c = {2'b00, off_reg};
        map_sum_c = {{(MB-WB){origin_re_reg[WB-1]}}, origin_re_reg} + off_ext_c;
        if (state_reg == S_MAP_END)
            map_sum_c = {{(MB-WB){origin_im_reg[WB-1]}}, origin_im_reg} + off_ext_c;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    px_next    = in_data.pixel_x;
                    py_next    = in_data.pixel_y;
                    iter_next  = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    state_next = S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                off_next   = OB'(px_reg) * OB'(step_reg);
                state_next = S_MAP_IM;
            end
            S_MAP_IM:
            begin
                cr_next    = mbe_pkg::sat_map(map_sum_c);
                off_next   = OB'(py_reg) * OB'(step_reg);
                state_next = S_MAP_END;
            end
            S_MAP_END:
            begin
                ci_next    = mbe_pkg::sat_map(map_sum_c);
                state_next = S_SQ_R;
            end
            S_SQ_R:
            begin
                mul_start  = 1'b1;
                state_next = S_WAIT_R;
            end
            S_WAIT_R:
            begin
                if (mul_done)
                begin
                    sr_next    = mul_p;
                    mul_start  = 1'b1;
                    mul_a      = zi_reg;
                    mul_b      = zi_reg;
                    state_next = S_WAIT_I;
                end
            end
            S_WAIT_I:
            begin
                if (mul_done)
                begin
                    si_next    = mul_p;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                diff_next = mbe_pkg::sat_word({sr_reg[WB-1], sr_reg} - {si_reg[WB-1], si_reg});
                if (escape_c || iter_reg >= max_iter_reg)
                    state_next = S_DONE;
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = zi_reg;
                    mul_b      = zr_reg;
                    state_next = S_WAIT_X;
                end
            end
            S_WAIT_X:
            begin
                if (mul_done)
                begin
                    cross_next = mbe_pkg::sat_word({mul_p[WB-1], mul_p} + {mul_p[WB-1], mul_p});
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                zr_next    = mbe_pkg::sat_word({diff_reg[WB-1], diff_reg}
                                               + {cr_reg[WB-1], cr_reg});
                zi_next    = mbe_pkg::sat_word({cross_reg[WB-1], cross_reg}
                                               + {ci_reg[WB-1], ci_reg});
                iter_next  = iter_reg + IB'(1);
                state_next = S_SQ_R;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.out_x       = px_reg;
                    out_next.out_y       = py_reg;
                    out_next.iterations  = iter_reg;
                    out_next.in_set      = inside_c;
                    out_next.fill_colour = (inside_c && white_reg) ? mbe_pkg::WHITE
                                                                   : mbe_pkg::BLACK;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        off_reg   <= off_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        sr_reg    <= sr_next;
        si_reg    <= si_next;
        diff_reg  <= diff_next;
        cross_reg <= cross_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= mbe_pkg::STEP_RESET;
            origin_re_reg <= mbe_pkg::ORIGIN_RESET;
            origin_im_reg <= mbe_pkg::ORIGIN_RESET;
            max_iter_reg  <= mbe_pkg::ITER_RESET;
            white_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbe_pkg::CFG_STEP_SIZE:    step_reg      <= cfg_data[mbe_pkg::STEP_BITS-1:0];
                mbe_pkg::CFG_ORIGIN_RE:    origin_re_reg <= mbe_pkg::word_t'(cfg_data);
                mbe_pkg::CFG_ORIGIN_IM:    origin_im_reg <= mbe_pkg::word_t'(cfg_data);
                mbe_pkg::CFG_MAX_ITER:     max_iter_reg  <= cfg_data[IB-1:0];
                mbe_pkg::CFG_IN_SET_WHITE: white_reg     <= cfg_data[0];
                default:                   white_reg     <= white_reg;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_WAIT_R || state_reg == S_WAIT_I
                      || state_reg == S_WAIT_X))
        else $error("multiplier result arrived outside a wait state");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (iter_reg <= max_iter_reg))
        else $error("iteration count passed the limit");

    a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.in_set) |-> (out_reg.iterations == max_iter_reg))
        else $error("in-set word without a full iteration count");

endmodule

// File: src/mbe_fxmul.sv
// ----------------------------------------------------------------------------
// mbe_fxmul
// Sequential fixed-point multiplier: magnitude product over two partial
// products, one per half of b; truncate, saturate and apply the sign.
// ----------------------------------------------------------------------------
module mbe_fxmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mbe_pkg::word_t a,
    input  mbe_pkg::word_t b,
    output logic          done,
    output mbe_pkg::word_t p
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_ROUND = 2'd2;

    localparam int WB = mbe_pkg::WORD_BITS;
    localparam int HB = mbe_pkg::HALF_BITS;
    localparam int PB = mbe_pkg::PROD_BITS;
    localparam int QB = mbe_pkg::Q_BITS;
    localparam int LB = WB + HB;

    logic [1:0]    phase_reg;
    logic [WB-1:0] ua_reg;
    logic [HB-1:0] ub_hi_reg;
    logic          neg_reg;
    logic [PB-1:0] acc_reg;
    logic          done_reg;
    mbe_pkg::word_t p_reg;

    logic [WB-1:0] ua_c;
    logic [WB-1:0] ub_c;
    logic [LB-1:0] pp_lo_c;
    logic [LB-1:0] pp_hi_c;
    logic [QB-1:0] q_c;
    logic [QB-1:0] cap_c;
    logic [QB-1:0] qs_c;
    mbe_pkg::word_t p_c;

    always_comb
    begin
        ua_c    = a[WB-1] ? (~a + WB'(1)) : a;
        ub_c    = b[WB-1] ? (~b + WB'(1)) : b;
        pp_lo_c = LB'(ua_c) * LB'(ub_c[HB-1:0]);
        pp_hi_c = LB'(ua_reg) * LB'(ub_hi_reg);
        q_c     = acc_reg[PB-1:mbe_pkg::FRAC_BITS];
        cap_c   = neg_reg ? (QB'(1) << (WB-1)) : ((QB'(1) << (WB-1)) - QB'(1));
        qs_c    = (q_c > cap_c) ? cap_c : q_c;
        p_c     = neg_reg ? mbe_pkg::word_t'(~qs_c[WB-1:0] + WB'(1))
                          : mbe_pkg::word_t'(qs_c[WB-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == PH_ROUND);
            case (phase_reg)
                PH_IDLE:  phase_reg <= start ? PH_HIGH : PH_IDLE;
                PH_HIGH:  phase_reg <= PH_ROUND;
                PH_ROUND: phase_reg <= PH_IDLE;
                default:  phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            ua_reg    <= ua_c;
            ub_hi_reg <= ub_c[WB-1:HB];
            neg_reg   <= a[WB-1] ^ b[WB-1];
            acc_reg   <= PB'(pp_lo_c);
        end
        else if (phase_reg == PH_HIGH)
        begin
            acc_reg <= acc_reg + {pp_hi_c[PB-HB-1:0], {HB{1'b0}}};
        end
        if (phase_reg == PH_ROUND)
            p_reg <= p_c;
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// File: bench/mandelbrot_escape_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Drives pixel words through the escape-time evaluator under random
// handshake gaps and register settings. A fixed-point predictor computes
// each expected result the stimulus table lacks; each received word is
// compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_tb;

    localparam int     WORD_BITS      = mbe_pkg::WORD_BITS;
    localparam int     FRAC_BITS      = mbe_pkg::FRAC_BITS;
    localparam int     ITER_BITS      = mbe_pkg::ITER_BITS;
    localparam int     PIX_BITS       = mbe_pkg::PIX_BITS;
    localparam int     STEP_BITS      = mbe_pkg::STEP_BITS;
    localparam int     PROD_BITS      = mbe_pkg::PROD_BITS;
    localparam int     COLOUR_BITS    = mbe_pkg::COLOUR_BITS;
    localparam int     CFG_IDX_BITS   = mbe_pkg::CFG_IDX_BITS;

    localparam int     STALL_LIMIT    = 20000;
    localparam int     PHASES         = 26;
    localparam int     PHASE_PIXELS   = 75;
    localparam int     HOLD_AT        = 200;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     TAIL_CYCLES    = 40;
    localparam longint WORD_TOP       = (longint'(1) << (WORD_BITS - 1)) - 1;
    localparam longint WORD_BOT       = -WORD_TOP - 1;
    localparam longint FOUR_Q         = longint'(4) << FRAC_BITS;

    typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [WORD_BITS-1:0]     value;
        mbe_pkg::in_word_t        pix;
        bit                       known;
        mbe_pkg::out_word_t       want;
    } stim_row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [WORD_BITS-1:0]    cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    mbe_pkg::in_word_t       in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    mbe_pkg::out_word_t      out_data;

    logic [STEP_BITS-1:0]    step_sz   = mbe_pkg::STEP_RESET;
    longint                  org_re    = longint'(mbe_pkg::ORIGIN_RESET);
    longint                  org_im    = longint'(mbe_pkg::ORIGIN_RESET);
    int                      iter_cap  = int'(mbe_pkg::ITER_RESET);
    bit                      paint_white = 1'b0;

    mbe_pkg::out_word_t      pending_results[$];
    stim_row_t               stim_table[$];
    int                      errors       = 0;
    int                      quiet_cycles = 0;
    bit                      in_burst     = 1'b0;
    bit                      out_burst    = 1'b0;

    mandelbrot_escape_time dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        longint r;
        r = v;
        if (v > WORD_TOP)
            r = WORD_TOP;
        else if (v < WORD_BOT)
            r = WORD_BOT;
        return r;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [PROD_BITS-1:0] ma;
        logic [PROD_BITS-1:0] mb;
        logic [PROD_BITS-1:0] q;
        logic [PROD_BITS-1:0] cap;
        bit                   neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? PROD_BITS'(-a) : PROD_BITS'(a);
        mb  = (b < 0) ? PROD_BITS'(-b) : PROD_BITS'(b);
        q   = (ma * mb) >> FRAC_BITS;
        cap = (PROD_BITS'(1) << (WORD_BITS - 1)) - (neg ? 0 : 1);
        if (q > cap)
            q = cap;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic mbe_pkg::out_word_t escape_pixel(input mbe_pkg::in_word_t w);
        longint             cr;
        longint             ci;
        longint             zr;
        longint             zi;
        longint             sr;
        longint             si;
        longint             twice_xy;
        int                 n;
        mbe_pkg::out_word_t r;
        cr = clamp_word(org_re + longint'(w.pixel_x) * longint'(step_sz));
        ci = clamp_word(org_im + longint'(w.pixel_y) * longint'(step_sz));
        zr = 0;
        zi = 0;
        n  = 0;
        forever
        begin
            sr = q_mul(zr, zr);
            si = q_mul(zi, zi);
            if (sr + si >= FOUR_Q || n >= iter_cap)
                break;
            twice_xy = clamp_word(2 * q_mul(zi, zr));
            zr       = clamp_word(clamp_word(sr - si) + cr);
            zi       = clamp_word(twice_xy + ci);
            n++;
        end
        r.out_x       = w.pixel_x;
        r.out_y       = w.pixel_y;
        r.iterations  = ITER_BITS'(n);
        r.in_set      = (n == iter_cap);
        r.fill_colour = (r.in_set && paint_white) ? mbe_pkg::WHITE : mbe_pkg::BLACK;
        return r;
    endfunction

    task automatic row_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [WORD_BITS-1:0] value);
        stim_row_t row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.value = value;
        row.pix   = '0;
        row.known = 1'b0;
        row.want  = '0;
        stim_table.push_back(row);
    endtask

    task automatic row_pixel(input int x, input int y, input bit known,
                             input int iters, input bit set_flag,
                             input logic [COLOUR_BITS-1:0] fill);
        stim_row_t row;
        row.kind             = ROW_PIXEL;
        row.idx              = '0;
        row.value            = '0;
        row.pix.pixel_x      = PIX_BITS'(x);
        row.pix.pixel_y      = PIX_BITS'(y);
        row.known            = known;
        row.want.out_x       = PIX_BITS'(x);
        row.want.out_y       = PIX_BITS'(y);
        row.want.iterations  = ITER_BITS'(iters);
        row.want.in_set      = set_flag;
        row.want.fill_colour = fill;
        stim_table.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [WORD_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            mbe_pkg::CFG_STEP_SIZE:    step_sz     = value[STEP_BITS-1:0];
            mbe_pkg::CFG_ORIGIN_RE:    org_re      = longint'(mbe_pkg::word_t'(value));
            mbe_pkg::CFG_ORIGIN_IM:    org_im      = longint'(mbe_pkg::word_t'(value));
            mbe_pkg::CFG_MAX_ITER:     iter_cap    = int'(value[ITER_BITS-1:0]);
            mbe_pkg::CFG_IN_SET_WHITE: paint_white = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // drop valid and wait until every pending result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic offer_pixel(input mbe_pkg::in_word_t w, input bit known,
                               input mbe_pkg::out_word_t want);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(known ? want : escape_pixel(w));
        @(negedge clk);
    endtask

    task automatic check_result(input mbe_pkg::out_word_t got);
        mbe_pkg::out_word_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected word for pixel (%0d, %0d)", got.out_x, got.out_y);
            errors++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.out_x !== want.out_x)
            begin
                $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== want.out_y)
            begin
                $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
                errors++;
            end
            if (got.iterations !== want.iterations)
            begin
                $error("iterations: expected %0d, got %0d", want.iterations, got.iterations);
                errors++;
            end
            if (got.in_set !== want.in_set)
            begin
                $error("in_set: expected %0d, got %0d", want.in_set, got.in_set);
                errors++;
            end
            if (got.fill_colour !== want.fill_colour)
            begin
                $error("fill_colour: expected %06h, got %06h", want.fill_colour,
                       got.fill_colour);
                errors++;
            end
        end
    endtask

    task automatic random_setting();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                write_reg(mbe_pkg::CFG_STEP_SIZE, WORD_BITS'($urandom()));
                write_reg(mbe_pkg::CFG_ORIGIN_RE, WORD_BITS'({$urandom(), $urandom()}));
                write_reg(mbe_pkg::CFG_ORIGIN_IM, WORD_BITS'({$urandom(), $urandom()}));
                write_reg(mbe_pkg::CFG_MAX_ITER, WORD_BITS'($urandom_range(1, 16)));
            end
            1:
            begin
                // real part far outside, so every pixel escapes after the first iteration
                write_reg(mbe_pkg::CFG_STEP_SIZE, WORD_BITS'($urandom()));
                write_reg(mbe_pkg::CFG_ORIGIN_RE, {2'b01, 34'({$urandom(), $urandom()})});
                write_reg(mbe_pkg::CFG_ORIGIN_IM, WORD_BITS'({$urandom(), $urandom()}));
                write_reg(mbe_pkg::CFG_MAX_ITER, WORD_BITS'($urandom_range(0, 1) ? 65535
                                                   : $urandom_range(40000, 65535)));
            end
            default:
            begin
                write_reg(mbe_pkg::CFG_STEP_SIZE,
                          WORD_BITS'($urandom_range(1 << 12, 1 << 21)));
                write_reg(mbe_pkg::CFG_ORIGIN_RE,
                          WORD_BITS'(longint'($urandom_range(0, 3 << 28))
                                     - (longint'(5) << 27)));
                write_reg(mbe_pkg::CFG_ORIGIN_IM,
                          WORD_BITS'(longint'($urandom_range(0, 3 << 28))
                                     - (longint'(3) << 27)));
                write_reg(mbe_pkg::CFG_MAX_ITER, WORD_BITS'((kind == 2) ? $urandom_range(33, 64)
                                                   : $urandom_range(0, 16)));
            end
        endcase
        write_reg(mbe_pkg::CFG_IN_SET_WHITE, WORD_BITS'($urandom_range(0, 1)));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int taken;
        int gap;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_burst = !out_burst;
            gap = out_burst ? 0 : $urandom_range(0, 7);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            check_result(out_data);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        mbe_pkg::in_word_t  pix;
        mbe_pkg::out_word_t none;
        none = '0;

        row_pixel(0, 0, 1, 1, 0, mbe_pkg::BLACK);
        row_pixel(1023, 1023, 1, 1, 0, mbe_pkg::BLACK);
        row_pixel(512, 512, 1, 50, 1, mbe_pkg::BLACK);
        row_pixel(256, 512, 0, 0, 0, mbe_pkg::BLACK);
        row_pixel(640, 512, 0, 0, 0, mbe_pkg::BLACK);
        row_pixel(600, 700, 0, 0, 0, mbe_pkg::BLACK);
        row_cfg(mbe_pkg::CFG_IN_SET_WHITE, 36'd1);
        row_pixel(512, 512, 1, 50, 1, mbe_pkg::WHITE);
        row_cfg(mbe_pkg::CFG_MAX_ITER, 36'd0);
        row_pixel(0, 0, 1, 0, 1, mbe_pkg::WHITE);
        row_pixel(1023, 1023, 1, 0, 1, mbe_pkg::WHITE);
        row_cfg(mbe_pkg::CFG_MAX_ITER, 36'd1);
        row_pixel(0, 0, 1, 1, 1, mbe_pkg::WHITE);
        row_pixel(512, 512, 1, 1, 1, mbe_pkg::WHITE);
        row_cfg(mbe_pkg::CFG_IN_SET_WHITE, 36'd0);
        row_cfg(mbe_pkg::CFG_MAX_ITER, 36'd65535);
        row_cfg(mbe_pkg::CFG_ORIGIN_RE, mbe_pkg::WMAX);
        row_cfg(mbe_pkg::CFG_ORIGIN_IM, mbe_pkg::WMIN);
        row_cfg(mbe_pkg::CFG_STEP_SIZE, 36'hFFFFFFFF);
        row_pixel(0, 0, 1, 1, 0, mbe_pkg::BLACK);
        row_pixel(1023, 1023, 1, 1, 0, mbe_pkg::BLACK);
        row_pixel(1023, 0, 0, 0, 0, mbe_pkg::BLACK);
        row_cfg(mbe_pkg::CFG_STEP_SIZE, 36'd0);
        row_cfg(mbe_pkg::CFG_ORIGIN_RE, mbe_pkg::ORIGIN_RESET);
        row_cfg(mbe_pkg::CFG_ORIGIN_IM, 36'd0);
        row_pixel(1023, 5, 0, 0, 0, mbe_pkg::BLACK);
        row_pixel(0, 1023, 0, 0, 0, mbe_pkg::BLACK);
        row_cfg(mbe_pkg::CFG_STEP_SIZE, 36'd1);
        row_cfg(mbe_pkg::CFG_ORIGIN_RE, mbe_pkg::WMIN);
        row_cfg(mbe_pkg::CFG_ORIGIN_IM, mbe_pkg::WMAX);
        row_cfg(mbe_pkg::CFG_MAX_ITER, 36'd50);
        row_pixel(1023, 1023, 0, 0, 0, mbe_pkg::BLACK);
        row_cfg(mbe_pkg::CFG_ORIGIN_RE, WORD_BITS'(-(longint'(3) << 26)));
        row_cfg(mbe_pkg::CFG_ORIGIN_IM, 36'd0);
        row_pixel(1023, 1023, 0, 0, 0, mbe_pkg::BLACK);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(stim_table[i].idx, stim_table[i].value);
            end
            else
                offer_pixel(stim_table[i].pix, stim_table[i].known, stim_table[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            random_setting();
            for (int k = 0; k < PHASE_PIXELS; k++)
            begin
                pix.pixel_x = PIX_BITS'($urandom_range(0, 1023));
                pix.pixel_y = PIX_BITS'($urandom_range(0, 1023));
                offer_pixel(pix, 1'b0, none);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
